@@ src/nec_pkg.sv @@
// ----------------------------------------------------------------------------
// nec_pkg
// Shared constants for the NEC infrared frame decoder: unit timing,
// period thresholds, frame lengths and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nec_pkg;

	// timer ticks per NEC timing unit
	localparam int unsigned UNIT_TICKS = 375;

	// period compare width: holds 97 units at the largest unit size
	localparam int unsigned TICK_CMP_W = 20;

	localparam int unsigned SHORT_UNITS = 9;   // below this: too short, clears
	localparam int unsigned CLEAR_UNITS = 13;  // start-of-frame gap, clears
	localparam int unsigned MAX_UNITS   = 96;  // above this: too long, clears

	// period thresholds in ticks (unit count = ticks / UNIT_TICKS)
	localparam logic [TICK_CMP_W-1:0] LIM_1U  = TICK_CMP_W'(UNIT_TICKS * 1);
	localparam logic [TICK_CMP_W-1:0] LIM_2U  = TICK_CMP_W'(UNIT_TICKS * 2);
	localparam logic [TICK_CMP_W-1:0] LIM_3U  = TICK_CMP_W'(UNIT_TICKS * 3);
	localparam logic [TICK_CMP_W-1:0] LIM_SHORT =
		TICK_CMP_W'(UNIT_TICKS * SHORT_UNITS);
	localparam logic [TICK_CMP_W-1:0] LIM_CLR_LO =
		TICK_CMP_W'(UNIT_TICKS * CLEAR_UNITS);
	localparam logic [TICK_CMP_W-1:0] LIM_CLR_HI =
		TICK_CMP_W'(UNIT_TICKS * (CLEAR_UNITS + 1));
	localparam logic [TICK_CMP_W-1:0] LIM_LONG =
		TICK_CMP_W'(UNIT_TICKS * (MAX_UNITS + 1));

	// frame lengths in bits
	localparam logic [7:0] ADDR_BITS  = 8'd16;
	localparam logic [7:0] FRAME_BITS = 8'd32;

	// reset values of the configuration registers
	localparam logic [15:0] ADDR_A_RESET = 16'hFF00;
	localparam logic [15:0] ADDR_B_RESET = 16'hFD02;

	// input action codes
	localparam logic ACT_CAPTURE  = 1'b0;
	localparam logic ACT_OVERFLOW = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ADDR_A = 2'd0,
		CFG_ADDR_B = 2'd1,
		CFG_IGNORE = 2'd2
	} cfg_index_t;

endpackage

@@ src/nec_ir_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_unit
// Decodes NEC infrared frames from edge-to-edge timer periods. Each input
// transaction is a captured period or a timer overflow; each one yields
// exactly one result transaction with the key status, the command byte, the
// latched address and the running bit count. The block takes one
// transaction per cycle while the output is not stalled: an input register
// (s1) feeds a combinational state update that writes the result register.
// The rate is set by that single update of the bit counter and shift
// register. The output register stalls the input stage only while a result
// waits to be taken. Configuration writes complete at once (cfg_ready is
// always high); the user must make them while the block holds no
// transaction in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_ir_frame_decoder_unit
	import nec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] period_ticks,

	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        key_valid,
	output logic [7:0]  command_byte,
	output logic [15:0] address_code,
	output logic [7:0]  bits_received,
	output logic        check_failed
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] addr_a_q;
	logic [15:0] addr_b_q;
	logic        ignore_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_a_q <= ADDR_A_RESET;
			addr_b_q <= ADDR_B_RESET;
			ignore_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ADDR_A: addr_a_q <= cfg_data;
				CFG_ADDR_B: addr_b_q <= cfg_data;
				CFG_IGNORE: ignore_q <= cfg_data[0];
				default:    ; // write beyond the register list is dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: input register (s1) then result register
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic        action_s1;
	logic [15:0] ticks_s1;
	logic        out_stall;
	logic        fire_s1;

	assign out_stall = out_valid && !out_ready;
	assign in_ready  = !valid_s1 || !out_stall;
	assign fire_s1   = valid_s1 && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			ticks_s1  <= period_ticks;
		end
	end

	// ------------------------------------------------------------------
	// Period classification by threshold compares (no divider)
	// ------------------------------------------------------------------
	logic [TICK_CMP_W-1:0] ticks_ext;
	logic                  is_one;
	logic                  is_zero;
	logic                  is_clear;

	assign ticks_ext = TICK_CMP_W'(ticks_s1);
	assign is_zero   = (ticks_ext >= LIM_1U) && (ticks_ext < LIM_2U);  // one unit
	assign is_one    = (ticks_ext >= LIM_2U) && (ticks_ext < LIM_3U);  // two units
	// zero or 3..8 units, the start gap, or too long
	assign is_clear  = (ticks_ext < LIM_SHORT) ||
	                   ((ticks_ext >= LIM_CLR_LO) && (ticks_ext < LIM_CLR_HI)) ||
	                   (ticks_ext >= LIM_LONG);

	// ------------------------------------------------------------------
	// Frame state update
	// ------------------------------------------------------------------
	logic [7:0]  count_q;
	logic [15:0] shift_q;
	logic [15:0] addr_q;

	logic [7:0]  count_upd;
	logic [15:0] shift_upd;
	logic [15:0] addr_upd;
	logic [7:0]  count_nxt;
	logic        valid_nxt;
	logic        failed_nxt;

	always_comb begin
		count_upd = count_q;
		shift_upd = shift_q;
		addr_upd  = addr_q;
		if (action_s1 == ACT_OVERFLOW) begin
			count_upd = '0;
		end else if (!ignore_q) begin
			priority if (is_zero || is_one) begin
				shift_upd = {is_one, shift_q[15:1]};
				count_upd = count_q + 8'd1;
			end else if (is_clear) begin
				count_upd = '0;
			end else begin
				// 9..12 or 14..96 units: period ignored
			end
			if (count_upd == ADDR_BITS) begin
				addr_upd = shift_upd;
			end
		end
	end

	// completed frame: command byte must be the inverse of its partner byte
	always_comb begin
		count_nxt  = count_upd;
		valid_nxt  = 1'b0;
		failed_nxt = 1'b0;
		if (count_upd == FRAME_BITS) begin
			if (shift_upd[7:0] != ~shift_upd[15:8]) begin
				count_nxt  = '0;
				failed_nxt = 1'b1;
			end else begin
				valid_nxt = (addr_upd == addr_a_q) || (addr_upd == addr_b_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			shift_q <= '0;
			addr_q  <= '0;
		end else if (fire_s1) begin
			count_q <= count_nxt;
			shift_q <= shift_upd;
			addr_q  <= addr_upd;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic        out_valid_q;
	logic        key_valid_q;
	logic        check_failed_q;
	logic [7:0]  command_q;
	logic [15:0] address_q;
	logic [7:0]  bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			key_valid_q    <= valid_nxt;
			check_failed_q <= failed_nxt;
			command_q      <= shift_upd[7:0];
			address_q      <= addr_upd;
			bits_q         <= count_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign key_valid     = key_valid_q;
	assign check_failed  = check_failed_q;
	assign command_byte  = command_q;
	assign address_code  = address_q;
	assign bits_received = bits_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_failed |-> bits_received == 8'd0 && !key_valid)
		else $error("check failure did not clear the bit count");

	a_key_full_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> bits_received == FRAME_BITS &&
		command_byte == ~shift_q[15:8])
		else $error("key reported without a checked full frame");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> address_code == addr_q && bits_received == count_q &&
		command_byte == shift_q[7:0])
		else $error("result register out of step with frame state");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_stall |=> valid_s1 && $stable(ticks_s1) &&
		$stable(action_s1))
		else $error("stalled input stage lost its transaction");

endmodule

@@ sim/tb_nec_ir_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder_unit
// Self-checking bench for the NEC infrared frame decoder. A scoreboard class
// tracks the decoder state and predicts one result per input transaction.
// Directed periods probe every unit bin boundary. Random traffic then drives
// mostly well-formed frames aimed at the configured addresses, with corrupt
// inverses, aborts, noise and a long random bit run that keeps reaching the
// frame check. The address and ignore registers are changed between phases.
// Both channels get random idle and stall gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nec_ir_frame_decoder_unit;
	import nec_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	// one decoded result, field by field
	typedef struct packed {
		logic        key_valid;
		logic [7:0]  command_byte;
		logic [15:0] address_code;
		logic [7:0]  bits_received;
		logic        check_failed;
	} ir_result_t;

	// Decoder shadow: register copy, frame state and the queue of results
	// still owed by the block.
	class ir_frame_scoreboard;
		logic [15:0] addr_a;
		logic [15:0] addr_b;
		logic        ignore_capture;
		logic [7:0]  bit_count;
		logic [15:0] shift_reg;
		logic [15:0] addr_latch;
		ir_result_t  owed_q[$];
		int          mismatches;

		function new();
			addr_a         = ADDR_A_RESET;
			addr_b         = ADDR_B_RESET;
			ignore_capture = 1'b0;
			bit_count      = '0;
			shift_reg      = '0;
			addr_latch     = '0;
			mismatches     = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void write_reg(cfg_index_t idx, logic [15:0] val);
			case (idx)
				CFG_ADDR_A: addr_a = val;
				CFG_ADDR_B: addr_b = val;
				CFG_IGNORE: ignore_capture = val[0];
				default: ;
			endcase
		endfunction

		// advance the frame state by one accepted transaction
		function void note_input(logic act, logic [15:0] ticks);
			int unsigned units;
			ir_result_t  res;
			units = ticks / UNIT_TICKS;
			res   = '0;
			if (act == ACT_OVERFLOW) begin
				bit_count = '0;
			end else if (!ignore_capture) begin
				if (units == 1 || units == 2) begin
					shift_reg = {units == 2, shift_reg[15:1]};
					bit_count = bit_count + 8'd1;
				end else if (units == CLEAR_UNITS || units < SHORT_UNITS ||
					units > MAX_UNITS) begin
					bit_count = '0;
				end
				if (bit_count == ADDR_BITS)
					addr_latch = shift_reg;
			end
			// command must be the bitwise inverse of the high byte
			if (bit_count == FRAME_BITS) begin
				if (shift_reg[7:0] != ~shift_reg[15:8]) begin
					bit_count        = '0;
					res.check_failed = 1'b1;
				end else if (addr_latch == addr_a || addr_latch == addr_b) begin
					res.key_valid = 1'b1;
				end
			end
			res.command_byte  = shift_reg[7:0];
			res.address_code  = addr_latch;
			res.bits_received = bit_count;
			owed_q.push_back(res);
		endfunction

		function void mismatch(string what, logic [15:0] want, logic [15:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
		endfunction

		function void check_result(ir_result_t got);
			ir_result_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transaction with nothing pending", $time);
				return;
			end
			want = owed_q.pop_front();
			if (got.key_valid !== want.key_valid)
				mismatch("key_valid", want.key_valid, got.key_valid);
			if (got.command_byte !== want.command_byte)
				mismatch("command_byte", want.command_byte, got.command_byte);
			if (got.address_code !== want.address_code)
				mismatch("address_code", want.address_code, got.address_code);
			if (got.bits_received !== want.bits_received)
				mismatch("bits_received", want.bits_received, got.bits_received);
			if (got.check_failed !== want.check_failed)
				mismatch("check_failed", want.check_failed, got.check_failed);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [15:0] period_ticks;
	logic        out_valid;
	logic        out_ready;
	logic        key_valid;
	logic [7:0]  command_byte;
	logic [15:0] address_code;
	logic [7:0]  bits_received;
	logic        check_failed;

	ir_frame_scoreboard sb;
	ir_result_t         seen;
	int                 sent_items = 0;
	int                 cycle_count = 0;
	bit                 calm_in = 1'b0;   // no sender gaps while set
	bit                 calm_out = 1'b0;  // no receiver stalls while set

	nec_ir_frame_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.period_ticks (period_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_valid    (key_valid),
		.command_byte (command_byte),
		.address_code (address_code),
		.bits_received(bits_received),
		.check_failed (check_failed)
	);

	always #5 clk = ~clk;

	// run guard: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_nec_ir_frame_decoder_unit: errors");
			$finish;
		end
	end

	// gap length: mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: stalls in stretches, with quiet stretches mixed in
	initial begin : result_sink
		int stall;
		int stretch;
		stall     = 0;
		stretch   = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				stretch  = $urandom_range(50, 300);
				calm_out = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			if (stall == 0 && !calm_out)
				stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// results are sampled with the values held before the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = '{key_valid, command_byte, address_code, bits_received,
				check_failed};
			sb.check_result(seen);
		end
	end

	// Tick ranges per unit bin. Bit periods are one or two units; the
	// leader gap (13 units) and the out-of-range bins clear the count.
	function automatic logic [15:0] bit_ticks(input logic b);
		if (b)
			return 16'($urandom_range(2 * UNIT_TICKS, 3 * UNIT_TICKS - 1));
		return 16'($urandom_range(UNIT_TICKS, 2 * UNIT_TICKS - 1));
	endfunction

	function automatic logic [15:0] leader_ticks();
		return 16'($urandom_range(CLEAR_UNITS * UNIT_TICKS,
			(CLEAR_UNITS + 1) * UNIT_TICKS - 1));
	endfunction

	// 9..12 or 14..96 units: no effect on the frame
	function automatic logic [15:0] ignored_ticks();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(SHORT_UNITS * UNIT_TICKS,
				CLEAR_UNITS * UNIT_TICKS - 1));
		return 16'($urandom_range((CLEAR_UNITS + 1) * UNIT_TICKS,
			(MAX_UNITS + 1) * UNIT_TICKS - 1));
	endfunction

	// zero units, 3..8, the leader bin or above 96
	function automatic logic [15:0] clearing_ticks();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, UNIT_TICKS - 1));
			1: return 16'($urandom_range(3 * UNIT_TICKS, SHORT_UNITS * UNIT_TICKS - 1));
			2: return leader_ticks();
			default: return 16'($urandom_range((MAX_UNITS + 1) * UNIT_TICKS, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 4))
			0, 1: return sb.addr_a;
			2, 3: return sb.addr_b;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// One input transaction. Valid stays high across back-to-back items;
	// it only drops when a gap is taken.
	task automatic send_item(input logic act, input logic [15:0] ticks);
		int gap;
		gap = calm_in ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		period_ticks <= ticks;
		do @(posedge clk); while (!in_ready);
		sb.note_input(act, ticks);
		sent_items++;
	endtask

	task automatic send_bit(input logic b);
		send_item(ACT_CAPTURE, bit_ticks(b));
	endtask

	task automatic send_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				send_item(ACT_OVERFLOW, 16'($urandom_range(0, 65535)));
			else
				send_item(ACT_CAPTURE, 16'($urandom_range(0, 65535)));
		end
	endtask

	// Full frame: start, 16 address bits, then command and its inverse,
	// each sent LSB first. Occasional ignored periods, aborts and corrupt
	// inverses; a short tail afterwards holds, extends or drops the frame.
	task automatic send_frame(input logic [15:0] addr, input logic [7:0] cmd,
		input bit corrupt);
		logic [15:0] data;
		data = {~cmd, cmd};
		if (corrupt)
			data = data ^ (16'h1 << $urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0)
			send_item(ACT_CAPTURE, leader_ticks());
		else
			send_item(ACT_OVERFLOW, 16'($urandom_range(0, 65535)));
		for (int k = 0; k < 32; k++) begin
			if ($urandom_range(0, 39) == 0)
				send_item(ACT_CAPTURE, ignored_ticks());
			if ($urandom_range(0, 199) == 0)
				send_item(ACT_CAPTURE, clearing_ticks());
			send_bit(k < 16 ? addr[k] : data[k - 16]);
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 3))
				0, 1: send_item(ACT_CAPTURE, ignored_ticks());
				2: send_bit(1'($urandom_range(0, 1)));
				default: send_item(ACT_OVERFLOW, 16'($urandom_range(0, 65535)));
			endcase
		end
	endtask

	// hold off the sender until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// registers only change with the block drained
	task automatic configure(input logic [15:0] a, input logic [15:0] b,
		input logic ign);
		drain_results();
		write_reg(CFG_ADDR_A, a);
		write_reg(CFG_ADDR_B, b);
		write_reg(CFG_IGNORE, {15'd0, ign});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(input int count);
		int stop_at;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			calm_in = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 39))
				0, 1, 2, 3, 4, 5: send_noise($urandom_range(1, 6));
				6: drain_results();
				default: send_frame(pick_addr(), 8'($urandom_range(0, 255)),
					$urandom_range(0, 6) == 0);
			endcase
		end
	endtask

	initial begin
		in_valid     = 1'b0;
		action       = ACT_CAPTURE;
		period_ticks = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_ADDR_A;
		cfg_data     = '0;
		arst_n       = 1'b0;
		sb           = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit bin edges, reset register values
		send_item(ACT_OVERFLOW, 16'hFFFF);
		send_item(ACT_CAPTURE, 16'd0);      // zero units clears
		send_item(ACT_CAPTURE, 16'd375);    // 0 bit
		send_item(ACT_CAPTURE, 16'd1124);   // 1 bit
		send_item(ACT_CAPTURE, 16'd374);    // just under one unit
		send_item(ACT_CAPTURE, 16'd749);
		send_item(ACT_CAPTURE, 16'd750);
		send_item(ACT_CAPTURE, 16'd1125);   // three units clears
		send_item(ACT_CAPTURE, 16'd375);
		send_item(ACT_CAPTURE, 16'd3374);   // eight units clears
		send_item(ACT_CAPTURE, 16'd1124);
		send_item(ACT_CAPTURE, 16'd3375);   // nine units ignored
		send_item(ACT_CAPTURE, 16'd4874);   // twelve units ignored
		send_item(ACT_CAPTURE, 16'd4875);   // leader clears
		send_item(ACT_CAPTURE, 16'd750);
		send_item(ACT_CAPTURE, 16'd5249);
		send_item(ACT_CAPTURE, 16'd375);
		send_item(ACT_CAPTURE, 16'd5250);   // fourteen units ignored
		send_item(ACT_CAPTURE, 16'd36374);  // 96 units ignored
		send_item(ACT_CAPTURE, 16'd36375);  // 97 units clears
		send_item(ACT_CAPTURE, 16'd1124);
		send_item(ACT_CAPTURE, 16'd65535);  // largest period clears
		send_item(ACT_OVERFLOW, 16'd0);

		configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
		run_traffic(400);

		// extreme addresses, then a long run of random bits
		configure(16'h0000, 16'hFFFF, 1'b0);
		send_item(ACT_OVERFLOW, 16'($urandom_range(0, 65535)));
		repeat (280) send_bit(1'($urandom_range(0, 1)));
		run_traffic(350);

		// captures frozen; only overflows move the count
		configure(16'h0000, 16'hFFFF, 1'b1);
		run_traffic(120);

		configure(16'hFFFF, 16'h0000, 1'b0);
		run_traffic(400);

		configure(ADDR_A_RESET, ADDR_B_RESET, 1'b0);
		run_traffic(400);

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_nec_ir_frame_decoder_unit: clean");
		else
			$display("tb_nec_ir_frame_decoder_unit: errors");
		$finish;
	end

endmodule
